// File: src/pfa_pkg.sv
// shared types and constants of the paged frame allocator
package pfa_pkg;

   localparam int MAX_PROCS  = 16;
   localparam int MAX_PAGES  = 64;
   localparam int NUM_FRAMES = 256;

   localparam int SLOT_W   = $clog2(MAX_PROCS);
   localparam int PAGE_W   = $clog2(MAX_PAGES);
   localparam int FRAME_W  = $clog2(NUM_FRAMES);
   localparam int CNT_W    = PAGE_W + 1;
   localparam int PT_DEPTH = MAX_PROCS * MAX_PAGES;
   localparam int PT_AW    = SLOT_W + PAGE_W;
   localparam int PTE_W    = FRAME_W + 1;
   localparam int PSZ_W    = 13;
   localparam int FCNT_W   = 9;
   localparam int SIZE_W   = 19;
   localparam int ACC_W    = SIZE_W + 1;
   localparam int CSR_AW   = 1;

   localparam logic [1:0] REQ_CREATE    = 2'd0;
   localparam logic [1:0] REQ_DESTROY   = 2'd1;
   localparam logic [1:0] REQ_RESIZE    = 2'd2;
   localparam logic [1:0] REQ_TRANSLATE = 2'd3;

   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_UNKNOWN = 3'd1;
   localparam logic [2:0] STS_NOFRAME = 3'd2;
   localparam logic [2:0] STS_TOOMANY = 3'd3;
   localparam logic [2:0] STS_NOSLOT  = 3'd4;
   localparam logic [2:0] STS_EXISTS  = 3'd5;
   localparam logic [2:0] STS_ABSENT  = 3'd6;

   localparam logic [CSR_AW-1:0] CSR_PAGE_SIZE   = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_FRAME_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] pid;
      logic [18:0] new_size;
      logic [5:0]  page_number;
   } pfa_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] frame;
      logic [6:0] page_count;
   } pfa_rsp_type;

endpackage

// File: src/paged_frame_allocator.sv
// top level of the paged frame allocator
//
// keeps one page table per process in 16 slots (64 pages each) and a
// 256-frame use bitmap, and serves create, destroy, resize and translate
// requests, one word in and one word out each. one request is worked at a
// time by a small sequencer: the slot search walks one slot a cycle over
// the 16 slots and stops at a pid match, a resize first multiplies the
// current page count by the page size, then counts pages by repeated add
// or subtract of the page size (one page a cycle), then grows by scanning
// the frame bitmap one frame a cycle from frame 0 (the scan never rewinds
// within one request and ends at the frame count), or shrinks page by
// page through S_SHR and S_SHRF, which waits on the page table
// ram's registered read. destroy frees its pages the same way, and the
// lookup of a translate passes S_XLT and S_XLTC. the page table ram
// needs no clearing pass after reset.
// the next request is taken while a finished response still waits on
// rsp_stall. config writes are taken any cycle and must only be issued
// while the block is idle.
module paged_frame_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pfa_pkg::pfa_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pfa_pkg::pfa_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfa_pkg::CSR_AW-1:0]         csr_index,
   input  logic [pfa_pkg::PSZ_W-1:0]          csr_wdata
);
   import pfa_pkg::*;

   // one-hot sequencer states
   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_SCAN = 13'b0000000000010,
      S_DISP = 13'b0000000000100,
      S_MUL  = 13'b0000000001000,
      S_RSZ  = 13'b0000000010000,
      S_UP   = 13'b0000000100000,
      S_DN   = 13'b0000001000000,
      S_GROW = 13'b0000010000000,
      S_SHR  = 13'b0000100000000,
      S_SHRF = 13'b0001000000000,
      S_XLT  = 13'b0010000000000,
      S_XLTC = 13'b0100000000000,
      S_FIN  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [PSZ_W-1:0]  page_size_ff, page_size_in;
   logic [FCNT_W-1:0] frame_count_ff, frame_count_in;

   // slot table and frame bitmap
   logic [MAX_PROCS-1:0]  slot_valid_ff, slot_valid_in;
   logic [15:0]           slot_pid_ff [MAX_PROCS];
   logic [15:0]           slot_pid_in [MAX_PROCS];
   logic [CNT_W-1:0]      slot_cnt_ff [MAX_PROCS];
   logic [CNT_W-1:0]      slot_cnt_in [MAX_PROCS];
   logic [NUM_FRAMES-1:0] used_ff, used_in;

   // working registers of the current request
   pfa_req_type       req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic              free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  n_ff, n_in;     // running page count
   logic [CNT_W-1:0]  k_ff, k_in;     // pages still to add or drop
   logic [ACC_W-1:0]  acc_ff, acc_in; // byte size being stepped
   logic [FCNT_W-1:0] ptr_ff, ptr_in; // frame scan pointer
   logic [2:0]        sts_ff, sts_in;
   logic [7:0]        frame_ff, frame_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type rsp_data_ff, rsp_data_in;

   // page table ram: {present, frame}
   logic             pt_we;
   logic [PT_AW-1:0] pt_waddr, pt_raddr;
   logic [PTE_W-1:0] pt_wdata, pt_rdata;

   logic [PSZ_W-1:0]  ps;
   logic [FCNT_W-1:0] lim;
   logic [ACC_W-1:0]  nsz;
   logic [CNT_W-1:0]  n_dec;

   assign ps    = (page_size_ff == '0) ? PSZ_W'(1) : page_size_ff;
   assign lim   = (frame_count_ff > FCNT_W'(NUM_FRAMES)) ? FCNT_W'(NUM_FRAMES) : frame_count_ff;
   assign nsz   = {1'b0, req_ff.new_size};
   assign n_dec = n_ff - CNT_W'(1);

   assign pt_waddr = {slot_ff, n_ff[PAGE_W-1:0]};

   pfa_ram #(
      .WIDTH(PTE_W),
      .DEPTH(PT_DEPTH)
   ) u_pt_ram (
      .clock(clock),
      .we   (pt_we),
      .waddr(pt_waddr),
      .wdata(pt_wdata),
      .raddr(pt_raddr),
      .rdata(pt_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // config writes
   always_comb begin
      page_size_in   = page_size_ff;
      frame_count_in = frame_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_SIZE:   page_size_in   = csr_wdata;
            CSR_FRAME_COUNT: frame_count_in = csr_wdata[FCNT_W-1:0];
            default:         page_size_in   = page_size_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      slot_pid_in   = slot_pid_ff;
      slot_cnt_in   = slot_cnt_ff;
      used_in       = used_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      free_ok_in    = free_ok_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      ptr_in        = ptr_ff;
      sts_in        = sts_ff;
      frame_in      = frame_ff;
      cnt_in        = cnt_ff;
      pt_we         = 1'b0;
      pt_wdata      = '0;
      pt_raddr      = {slot_ff, n_dec[PAGE_W-1:0]};
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         // one slot a cycle: match on pid, remember lowest free slot
         S_SCAN: begin
            if (slot_valid_ff[idx_ff] && slot_pid_ff[idx_ff] == req_ff.pid) begin
               hit_in   = 1'b1;
               slot_in  = idx_ff;
               state_in = S_DISP;
            end else begin
               if (!slot_valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = idx_ff;
               end
               if (idx_ff == SLOT_W'(MAX_PROCS - 1)) begin
                  state_in = S_DISP;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         S_DISP: begin
            sts_in   = STS_OK;
            frame_in = '0;
            cnt_in   = '0;
            state_in = S_FIN;
            priority if (req_ff.req_type == REQ_CREATE) begin
               if (hit_ff) begin
                  sts_in = STS_EXISTS;
                  cnt_in = slot_cnt_ff[slot_ff];
               end else if (free_ok_ff) begin
                  slot_valid_in[free_ff] = 1'b1;
                  slot_pid_in[free_ff]   = req_ff.pid;
                  slot_cnt_in[free_ff]   = '0;
               end else begin
                  sts_in = STS_NOSLOT;
               end
            end else if (!hit_ff) begin
               sts_in = STS_UNKNOWN;
            end else if (req_ff.req_type == REQ_DESTROY) begin
               n_in     = slot_cnt_ff[slot_ff];
               k_in     = slot_cnt_ff[slot_ff];
               state_in = S_SHR;
            end else if (req_ff.req_type == REQ_RESIZE) begin
               n_in     = slot_cnt_ff[slot_ff];
               state_in = S_MUL;
            end else begin
               cnt_in = slot_cnt_ff[slot_ff];
               if ({1'b0, req_ff.page_number} >= slot_cnt_ff[slot_ff]) begin
                  sts_in = STS_ABSENT;
               end else begin
                  state_in = S_XLT;
               end
            end
         end
         // current byte size of the table
         S_MUL: begin
            acc_in   = ACC_W'(n_ff) * ACC_W'(ps);
            k_in     = '0;
            state_in = S_RSZ;
         end
         S_RSZ: begin
            if (nsz > acc_ff) begin
               state_in = S_UP;
            end else if (nsz < acc_ff) begin
               state_in = S_DN;
            end else begin
               cnt_in   = n_ff;
               state_in = S_FIN;
            end
         end
         // ceiling count of pages to add, stops once the table would overflow
         S_UP: begin
            if (acc_ff >= nsz) begin
               ptr_in   = '0;
               state_in = S_GROW;
            end else if (k_ff == CNT_W'(MAX_PAGES) - n_ff) begin
               sts_in   = STS_TOOMANY;
               cnt_in   = n_ff;
               state_in = S_FIN;
            end else begin
               acc_in = acc_ff + ACC_W'(ps);
               k_in   = k_ff + CNT_W'(1);
            end
         end
         // floor count of pages to drop, never below zero pages
         S_DN: begin
            if (k_ff == n_ff || acc_ff < nsz + ACC_W'(ps)) begin
               state_in = S_SHR;
            end else begin
               acc_in = acc_ff - ACC_W'(ps);
               k_in   = k_ff + CNT_W'(1);
            end
         end
         // lowest free frame for each new page; when frames run out, one absent page is added
         S_GROW: begin
            if (k_ff == '0) begin
               slot_cnt_in[slot_ff] = n_ff;
               cnt_in               = n_ff;
               state_in             = S_FIN;
            end else if (ptr_ff >= lim) begin
               pt_we                = 1'b1;
               pt_wdata             = '0;
               n_in                 = n_ff + CNT_W'(1);
               slot_cnt_in[slot_ff] = n_ff + CNT_W'(1);
               cnt_in               = n_ff + CNT_W'(1);
               sts_in               = STS_NOFRAME;
               state_in             = S_FIN;
            end else if (!used_ff[ptr_ff[FRAME_W-1:0]]) begin
               pt_we                         = 1'b1;
               pt_wdata                      = {1'b1, ptr_ff[FRAME_W-1:0]};
               used_in[ptr_ff[FRAME_W-1:0]]  = 1'b1;
               n_in                          = n_ff + CNT_W'(1);
               k_in                          = k_ff - CNT_W'(1);
               ptr_in                        = ptr_ff + FCNT_W'(1);
            end else begin
               ptr_in = ptr_ff + FCNT_W'(1);
            end
         end
         // drop pages from the end, read each entry to free its frame
         S_SHR: begin
            if (k_ff == '0) begin
               slot_cnt_in[slot_ff] = n_ff;
               if (req_ff.req_type == REQ_DESTROY) begin
                  slot_valid_in[slot_ff] = 1'b0;
                  cnt_in                 = '0;
               end else begin
                  cnt_in = n_ff;
               end
               state_in = S_FIN;
            end else begin
               n_in     = n_dec;
               k_in     = k_ff - CNT_W'(1);
               state_in = S_SHRF;
            end
         end
         S_SHRF: begin
            if (pt_rdata[PTE_W-1]) begin
               used_in[pt_rdata[FRAME_W-1:0]] = 1'b0;
            end
            state_in = S_SHR;
         end
         S_XLT: begin
            pt_raddr = {slot_ff, req_ff.page_number};
            state_in = S_XLTC;
         end
         S_XLTC: begin
            if (pt_rdata[PTE_W-1]) begin
               frame_in = pt_rdata[FRAME_W-1:0];
            end else begin
               sts_in = STS_ABSENT;
            end
            state_in = S_FIN;
         end
         // hand the word to the output register once it is free
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = sts_ff;
               rsp_data_in.frame      = frame_ff;
               rsp_data_in.page_count = cnt_ff;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         page_size_ff   <= PSZ_W'(32);
         frame_count_ff <= FCNT_W'(256);
         slot_valid_ff  <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            slot_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         page_size_ff   <= page_size_in;
         frame_count_ff <= frame_count_in;
         slot_valid_ff  <= slot_valid_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
         slot_cnt_ff    <= slot_cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      slot_pid_ff <= slot_pid_in;
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      free_ok_ff  <= free_ok_in;
      slot_ff     <= slot_in;
      free_ff     <= free_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      ptr_ff      <= ptr_in;
      sts_ff      <= sts_in;
      frame_ff    <= frame_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// File: src/pfa_ram.sv
// generic single write port ram with registered read
module pfa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sim/tb_top.sv
// self-checking testbench of the paged frame allocator
`timescale 1ns / 1ps

module tb_top;
   import pfa_pkg::*;

   // one directed row: a request, how often to repeat it with rising pid,
   // and the response where it is obvious (otherwise the predictor decides)
   typedef struct {
      pfa_req_type rq;
      int          rep;
      bit          pinned;
      pfa_rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   pfa_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   pfa_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_AW-1:0] csr_index;
   logic [PSZ_W-1:0]  csr_wdata;

   // shadow of the allocator state
   logic [PSZ_W-1:0]   sh_page_size;
   logic [FCNT_W-1:0]  sh_frame_count;
   bit                 sh_slot_valid [MAX_PROCS];
   logic [15:0]        sh_slot_pid   [MAX_PROCS];
   int                 sh_slot_pages [MAX_PROCS];
   int                 sh_pte_frame  [MAX_PROCS][MAX_PAGES];
   bit                 sh_pte_present[MAX_PROCS][MAX_PAGES];
   bit                 sh_frame_used [NUM_FRAMES];

   pfa_rsp_type expected_rsp_q[$];
   int          fail_count;
   int          idle_mode;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
   bit          pin_now;
   pfa_rsp_type pin_rsp;
   row_type     rows[$];

   paged_frame_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous limit, far beyond the slowest legal run
   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // lowest free frame below the effective frame count, -1 when none
   function automatic int grab_frame();
      int lim;
      lim = (sh_frame_count < NUM_FRAMES) ? int'(sh_frame_count) : NUM_FRAMES;
      for (int f = 0; f < lim; f++) begin
         if (!sh_frame_used[f]) begin
            sh_frame_used[f] = 1'b1;
            return f;
         end
      end
      return -1;
   endfunction

   function automatic void drop_page(int s, int p);
      if (sh_pte_present[s][p]) sh_frame_used[sh_pte_frame[s][p]] = 1'b0;
      sh_pte_present[s][p] = 1'b0;
   endfunction

   // works out the response of one request and advances the shadow state
   function automatic pfa_rsp_type allocate_step(pfa_req_type r);
      pfa_rsp_type o;
      int ps, s, n, cur, need, drop, f;
      o = '0;
      o.status = STS_OK;
      ps = (sh_page_size == 0) ? 1 : int'(sh_page_size);
      s = MAX_PROCS;
      for (int k = MAX_PROCS - 1; k >= 0; k--)
         if (sh_slot_valid[k] && sh_slot_pid[k] == r.pid) s = k;
      if (r.req_type == REQ_CREATE) begin
         if (s < MAX_PROCS) begin
            o.status = STS_EXISTS;
            o.page_count = 7'(sh_slot_pages[s]);
         end else begin
            s = 0;
            while (s < MAX_PROCS && sh_slot_valid[s]) s++;
            if (s >= MAX_PROCS) o.status = STS_NOSLOT;
            else begin
               sh_slot_valid[s] = 1'b1;
               sh_slot_pid[s] = r.pid;
               sh_slot_pages[s] = 0;
            end
         end
      end else if (s >= MAX_PROCS) begin
         o.status = STS_UNKNOWN;
      end else if (r.req_type == REQ_DESTROY) begin
         for (int p = 0; p < sh_slot_pages[s]; p++) drop_page(s, p);
         sh_slot_pages[s] = 0;
         sh_slot_valid[s] = 1'b0;
      end else if (r.req_type == REQ_RESIZE) begin
         n = sh_slot_pages[s];
         cur = n * ps;
         if (int'(r.new_size) > cur) begin
            need = (int'(r.new_size) - cur + ps - 1) / ps;
            if (need > MAX_PAGES - n) o.status = STS_TOOMANY;
            else begin
               for (int k = 0; k < need; k++) begin
                  f = grab_frame();
                  n++;
                  if (f >= 0) begin
                     sh_pte_frame[s][n-1] = f;
                     sh_pte_present[s][n-1] = 1'b1;
                  end else begin
                     sh_pte_frame[s][n-1] = 0;
                     sh_pte_present[s][n-1] = 1'b0;
                     o.status = STS_NOFRAME;
                     break;
                  end
               end
               sh_slot_pages[s] = n;
            end
         end else if (int'(r.new_size) < cur) begin
            drop = (cur - int'(r.new_size)) / ps;
            if (drop > n) drop = n;
            for (int k = 0; k < drop; k++) begin
               n--;
               drop_page(s, n);
            end
            sh_slot_pages[s] = n;
         end
         o.page_count = 7'(sh_slot_pages[s]);
      end else begin
         o.page_count = 7'(sh_slot_pages[s]);
         if (r.page_number >= sh_slot_pages[s] || !sh_pte_present[s][r.page_number])
            o.status = STS_ABSENT;
         else
            o.frame = 8'(sh_pte_frame[s][r.page_number]);
      end
      return o;
   endfunction

   // every accepted request word gets its expectation at the accepting edge
   always @(posedge clock) begin
      pfa_rsp_type exp_rsp;
      if (!reset && req_valid && !req_stall) begin
         exp_rsp = allocate_step(req_data);
         expected_rsp_q.push_back(pin_now ? pin_rsp : exp_rsp);
      end
   end

   // response words are compared field by field with the oldest expectation
   always @(posedge clock) begin
      pfa_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected response word %h", rsp_data);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.status !== exp_rsp.status || rsp_data.frame !== exp_rsp.frame ||
                rsp_data.page_count !== exp_rsp.page_count) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected st %0d fr %0d pc %0d, got st %0d fr %0d pc %0d",
                           exp_rsp.status, exp_rsp.frame, exp_rsp.page_count,
                           rsp_data.status, rsp_data.frame, rsp_data.page_count);
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (idle_mode == 2) rsp_stall <= ($urandom_range(99) < 59);
      else if (idle_mode == 3) rsp_stall <= ($urandom_range(99) < 14);
      else rsp_stall <= 1'b0;
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_word(pfa_req_type d);
      int gap, pct;
      gap = 0;
      pct = (idle_mode == 1) ? 59 : (idle_mode == 3) ? 14 : 0;
      while (gap < 40 && $urandom_range(99) < pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [PSZ_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PAGE_SIZE) sh_page_size = val;
      else sh_frame_count = val[FCNT_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(logic [1:0] t, logic [15:0] pid, logic [18:0] sz,
                                   logic [5:0] pg, int rep, int pinned,
                                   logic [2:0] st, int fr, int pc);
      row_type r;
      r.rq = {t, pid, sz, pg};
      r.rep = rep;
      r.pinned = (pinned != 0);
      r.rsp = {st, 8'(fr), 7'(pc)};
      rows.push_back(r);
   endfunction

   task automatic run_rows();
      pfa_req_type rq;
      foreach (rows[i]) begin
         for (int k = 0; k < rows[i].rep; k++) begin
            rq = rows[i].rq;
            rq.pid = 16'(rq.pid + k);
            pin_now = rows[i].pinned;
            pin_rsp = rows[i].rsp;
            send_word(rq);
         end
      end
      pin_now = 1'b0;
      rows.delete();
   endtask

   // random request, mostly on a small pool of pids so tables fill and clash
   function automatic pfa_req_type random_word();
      pfa_req_type r;
      int w, ps;
      ps = (sh_page_size == 0) ? 1 : int'(sh_page_size);
      w = $urandom_range(99);
      r.req_type = (w < 20) ? REQ_CREATE : (w < 30) ? REQ_DESTROY :
                   (w < 70) ? REQ_RESIZE : REQ_TRANSLATE;
      r.pid = ($urandom_range(15) == 0) ? 16'($urandom) :
              ($urandom_range(20) == 0) ? 16'hffff : 16'($urandom_range(19));
      if ($urandom_range(15) == 0) r.new_size = 19'($urandom);
      else if (ps * 70 >= (1 << SIZE_W)) r.new_size = 19'($urandom);
      else r.new_size = 19'($urandom_range(ps * 70));
      r.page_number = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
      return r;
   endfunction

   initial begin
      logic [PSZ_W-1:0] psz_set[8];
      logic [PSZ_W-1:0] fcnt_set[8];
      fail_count = 0;
      idle_mode = 0;
      pin_now = 1'b0;
      pin_rsp = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_PAGE_SIZE;
      csr_wdata = '0;
      sh_page_size = 32;
      sh_frame_count = 256;
      foreach (sh_slot_valid[s]) begin
         sh_slot_valid[s] = 1'b0;
         sh_slot_pages[s] = 0;
      end
      foreach (sh_frame_used[f]) sh_frame_used[f] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset settings: page size 32, all 256 frames
      add_row(REQ_TRANSLATE, 16'd0,     19'd0,    6'd0,  1, 1, STS_UNKNOWN, 0, 0);
      add_row(REQ_DESTROY,   16'hffff,  19'd0,    6'd0,  1, 1, STS_UNKNOWN, 0, 0);
      add_row(REQ_RESIZE,    16'd5,     19'd100,  6'd0,  1, 1, STS_UNKNOWN, 0, 0);
      add_row(REQ_CREATE,    16'd0,     19'd0,    6'd0,  1, 1, STS_OK,      0, 0);
      add_row(REQ_CREATE,    16'd0,     19'd0,    6'd0,  1, 1, STS_EXISTS,  0, 0);
      add_row(REQ_CREATE,    16'hffff,  19'd0,    6'd0,  1, 1, STS_OK,      0, 0);
      add_row(REQ_RESIZE,    16'd0,     19'd1,    6'd0,  1, 1, STS_OK,      0, 1);
      add_row(REQ_TRANSLATE, 16'd0,     19'd0,    6'd0,  1, 1, STS_OK,      0, 1);
      add_row(REQ_TRANSLATE, 16'd0,     19'd0,    6'd63, 1, 1, STS_ABSENT,  0, 1);
      // exactly the full table, frames 1 to 64
      add_row(REQ_RESIZE,    16'hffff,  19'd2048, 6'd0,  1, 1, STS_OK,      0, 64);
      add_row(REQ_RESIZE,    16'hffff,  19'd2049, 6'd0,  1, 1, STS_TOOMANY, 0, 64);
      add_row(REQ_TRANSLATE, 16'hffff,  19'd0,    6'd63, 1, 1, STS_OK,      64, 64);
      add_row(REQ_RESIZE,    16'hffff,  19'd1000, 6'd0,  1, 0, STS_OK,      0, 0);
      add_row(REQ_RESIZE,    16'd0,     19'd0,    6'd0,  1, 1, STS_OK,      0, 0);
      add_row(REQ_DESTROY,   16'hffff,  19'h7ffff, 6'h3f, 1, 1, STS_OK,     0, 0);
      add_row(REQ_CREATE,    16'd1,     19'd0,    6'd0,  15, 1, STS_OK,     0, 0);
      // all sixteen slots taken
      add_row(REQ_CREATE,    16'd100,   19'd0,    6'd0,  1, 1, STS_NOSLOT,  0, 0);
      run_rows();
      wait_drained();

      // zero page size acts as one byte, only two frames to hand out
      write_csr(CSR_PAGE_SIZE, 13'd0);
      write_csr(CSR_FRAME_COUNT, 13'd2);
      add_row(REQ_RESIZE,    16'd1,     19'd3,    6'd0,  1, 1, STS_NOFRAME, 0, 3);
      add_row(REQ_TRANSLATE, 16'd1,     19'd0,    6'd1,  1, 1, STS_OK,      1, 3);
      add_row(REQ_TRANSLATE, 16'd1,     19'd0,    6'd2,  1, 1, STS_ABSENT,  0, 3);
      add_row(REQ_RESIZE,    16'd2,     19'd1,    6'd0,  1, 1, STS_NOFRAME, 0, 1);
      add_row(REQ_DESTROY,   16'd1,     19'd0,    6'd0,  1, 1, STS_OK,      0, 0);
      add_row(REQ_CREATE,    16'd2,     19'd0,    6'd0,  1, 1, STS_EXISTS,  0, 1);
      run_rows();
      wait_drained();

      // random phases, each with its own settings and idling pattern
      psz_set  = '{13'd32, 13'd1, 13'd0, 13'd4096, 13'h1fff, 13'd7, 13'd100, 13'd64};
      fcnt_set = '{13'd256, 13'd1, 13'd0, 13'h1ff, 13'd40, 13'd255, 13'd12, 13'd256};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_PAGE_SIZE, (ph == 6) ? 13'($urandom_range(1, 200)) : psz_set[ph]);
         write_csr(CSR_FRAME_COUNT, fcnt_set[ph]);
         idle_mode = ph % 4;
         for (int k = 0; k < 80; k++) begin
            // let everything drain once before carrying on
            if (ph == 2 && k == 40) wait_drained();
            send_word(random_word());
         end
         wait_drained();
      end

      repeat (500) @(negedge clock);
      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
